// ===== sv/shw_pkg.sv =====
// Shared types, codes and reset constants for the stream health watchdog.
`timescale 1ns / 1ps

package shw_pkg;

    // Field widths
    localparam int NOW_W     = 48;
    localparam int LAT_W     = 32;
    localparam int MS_W      = 16;
    localparam int CNT_W     = 4;
    localparam int RETRY_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Event codes
    localparam logic [1:0] FUNC_FRAME    = 2'd0;
    localparam logic [1:0] FUNC_TICK     = 2'd1;
    localparam logic [1:0] FUNC_START    = 2'd2;
    localparam logic [1:0] FUNC_BASELINE = 2'd3;

    // Reconnect cause codes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_CREEP   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CREEP_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CREEP_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_CAP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SHIFT   = 3'd5;

    // Configuration reset values
    localparam logic [MS_W-1:0]  RST_TIMEOUT     = 16'd12000;
    localparam logic [MS_W-1:0]  RST_CREEP_LIMIT = 16'd5000;
    localparam logic [CNT_W-1:0] RST_CREEP_TICKS = 4'd3;
    localparam logic [MS_W-1:0]  RST_BACKOFF_BASE = 16'd1000;
    localparam logic [MS_W-1:0]  RST_BACKOFF_CAP = 16'd15000;
    localparam logic [CNT_W-1:0] RST_MAX_SHIFT   = 4'd4;

    // Counter limits
    localparam logic [CNT_W-1:0]   CREEP_CNT_MAX = 4'hF;
    localparam logic [RETRY_W-1:0] RETRY_MAX     = 8'hFF;

    typedef struct packed {
        logic [MS_W-1:0]  timeout_ms;
        logic [MS_W-1:0]  creep_limit_ms;
        logic [CNT_W-1:0] creep_ticks_needed;
        logic [MS_W-1:0]  backoff_base_ms;
        logic [MS_W-1:0]  backoff_cap_ms;
        logic [CNT_W-1:0] backoff_max_shift;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [NOW_W-1:0] now_ms;
        logic             latency_valid;
        logic [LAT_W-1:0] latency_ms;
        logic             new_stream;
    } event_t;

    typedef struct packed {
        logic               reconnect;
        logic [1:0]         cause;
        logic [MS_W-1:0]    backoff_ms;
        logic [RETRY_W-1:0] attempt;
        logic [LAT_W-1:0]   creep_ms;
        logic               first_frame;
        logic               active;
    } result_t;

endpackage

// ===== sv/shw_cfg_regs.sv =====
// Configuration register bank of the stream health watchdog.
`timescale 1ns / 1ps

module shw_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [shw_pkg::MS_W-1:0]        cfg_data,
    output shw_pkg::cfg_t                   cfg
);

    shw_pkg::cfg_t cfg_reg;

    // Always able to take a write request
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the index and load the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms         <= shw_pkg::RST_TIMEOUT;
            cfg_reg.creep_limit_ms     <= shw_pkg::RST_CREEP_LIMIT;
            cfg_reg.creep_ticks_needed <= shw_pkg::RST_CREEP_TICKS;
            cfg_reg.backoff_base_ms    <= shw_pkg::RST_BACKOFF_BASE;
            cfg_reg.backoff_cap_ms     <= shw_pkg::RST_BACKOFF_CAP;
            cfg_reg.backoff_max_shift  <= shw_pkg::RST_MAX_SHIFT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                shw_pkg::REG_TIMEOUT:      cfg_reg.timeout_ms <= cfg_data;
                shw_pkg::REG_CREEP_LIMIT:  cfg_reg.creep_limit_ms <= cfg_data;
                shw_pkg::REG_CREEP_TICKS:
                    cfg_reg.creep_ticks_needed <= cfg_data[shw_pkg::CNT_W-1:0];
                shw_pkg::REG_BACKOFF_BASE: cfg_reg.backoff_base_ms <= cfg_data;
                shw_pkg::REG_BACKOFF_CAP:  cfg_reg.backoff_cap_ms <= cfg_data;
                shw_pkg::REG_MAX_SHIFT:
                    cfg_reg.backoff_max_shift <= cfg_data[shw_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/shw_core.sv =====
// Session state registers and the single-pass event evaluation logic.
`timescale 1ns / 1ps

module shw_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  shw_pkg::event_t   ev,
    input  shw_pkg::cfg_t     cfg,
    output shw_pkg::result_t  res
);

    // Session state
    logic                         active_reg;
    logic                         frame_seen_reg;
    logic [shw_pkg::NOW_W-1:0]    last_time_reg;
    logic [shw_pkg::LAT_W-1:0]    latest_lat_reg;
    logic [shw_pkg::LAT_W-1:0]    min_lat_reg;
    logic                         min_valid_reg;
    logic [shw_pkg::CNT_W-1:0]    creep_cnt_reg;
    logic [shw_pkg::RETRY_W-1:0]  retry_reg;

    logic                         active_next;
    logic                         frame_seen_next;
    logic [shw_pkg::NOW_W-1:0]    last_time_next;
    logic [shw_pkg::LAT_W-1:0]    latest_lat_next;
    logic [shw_pkg::LAT_W-1:0]    min_lat_next;
    logic                         min_valid_next;
    logic [shw_pkg::CNT_W-1:0]    creep_cnt_next;
    logic [shw_pkg::RETRY_W-1:0]  retry_next;

    logic [shw_pkg::NOW_W:0]      silent;
    logic                         timed_out;
    logic signed [shw_pkg::LAT_W:0] creep_cur;
    logic signed [shw_pkg::LAT_W:0] creep_limit_ext;
    logic                         creeping;
    logic                         lat_below_min;
    logic [shw_pkg::CNT_W-1:0]    creep_cnt_inc;
    logic [shw_pkg::RETRY_W-1:0]  retry_inc;
    logic [shw_pkg::CNT_W-1:0]    shift_amt;
    logic [shw_pkg::MS_W+14:0]    delay;
    logic [shw_pkg::MS_W-1:0]     backoff;
    logic [1:0]                   cause;
    logic                         first;
    logic signed [shw_pkg::LAT_W:0] creep_new;
    logic [shw_pkg::LAT_W-1:0]    creep_sat;

    // Silence since the last frame; negative silence never times out
    assign silent    = {1'b0, ev.now_ms} - {1'b0, last_time_reg};
    assign timed_out = !silent[shw_pkg::NOW_W]
                       && (silent[shw_pkg::NOW_W-1:0] > {32'd0, cfg.timeout_ms});

    // Creep against the session minimum, full precision
    assign creep_cur = min_valid_reg
        ? ($signed({latest_lat_reg[shw_pkg::LAT_W-1], latest_lat_reg})
           - $signed({min_lat_reg[shw_pkg::LAT_W-1], min_lat_reg}))
        : '0;
    assign creep_limit_ext = $signed({17'd0, cfg.creep_limit_ms});
    assign creeping        = creep_cur > creep_limit_ext;

    assign lat_below_min = $signed(ev.latency_ms) < $signed(min_lat_reg);

    // Saturating counter increments
    assign creep_cnt_inc = (creep_cnt_reg == shw_pkg::CREEP_CNT_MAX)
                           ? creep_cnt_reg : creep_cnt_reg + 1'b1;
    assign retry_inc     = (retry_reg == shw_pkg::RETRY_MAX)
                           ? retry_reg : retry_reg + 1'b1;

    // Backoff: base doubled per retry up to the shift limit, then capped
    assign shift_amt = (retry_reg < {4'd0, cfg.backoff_max_shift})
                       ? retry_reg[shw_pkg::CNT_W-1:0] : cfg.backoff_max_shift;
    assign delay     = {15'd0, cfg.backoff_base_ms} << shift_amt;
    assign backoff   = (delay < {15'd0, cfg.backoff_cap_ms})
                       ? delay[shw_pkg::MS_W-1:0] : cfg.backoff_cap_ms;

    // Evaluate one event against the current state
    always_comb
    begin
        active_next     = active_reg;
        frame_seen_next = frame_seen_reg;
        last_time_next  = last_time_reg;
        latest_lat_next = latest_lat_reg;
        min_lat_next    = min_lat_reg;
        min_valid_next  = min_valid_reg;
        creep_cnt_next  = creep_cnt_reg;
        retry_next      = retry_reg;
        cause           = shw_pkg::CAUSE_NONE;
        first           = 1'b0;

        unique case (ev.func)
            shw_pkg::FUNC_FRAME:
            begin
                if (active_reg)
                begin
                    last_time_next = ev.now_ms;
                    if (!frame_seen_reg)
                    begin
                        first           = 1'b1;
                        frame_seen_next = 1'b1;
                        retry_next      = '0;
                    end
                    if (ev.latency_valid)
                    begin
                        latest_lat_next = ev.latency_ms;
                        if (!min_valid_reg || lat_below_min)
                        begin
                            min_lat_next   = ev.latency_ms;
                            min_valid_next = 1'b1;
                        end
                    end
                end
            end
            shw_pkg::FUNC_TICK:
            begin
                if (active_reg)
                begin
                    if (timed_out)
                    begin
                        cause = shw_pkg::CAUSE_TIMEOUT;
                    end
                    else if (!creeping)
                    begin
                        creep_cnt_next = '0;
                    end
                    else
                    begin
                        creep_cnt_next = creep_cnt_inc;
                        if (creep_cnt_inc >= cfg.creep_ticks_needed)
                        begin
                            cause = shw_pkg::CAUSE_CREEP;
                        end
                    end
                    if (cause != shw_pkg::CAUSE_NONE)
                    begin
                        retry_next      = retry_inc;
                        active_next     = 1'b0;
                        frame_seen_next = 1'b0;
                    end
                end
            end
            shw_pkg::FUNC_START:
            begin
                active_next     = 1'b1;
                frame_seen_next = 1'b0;
                latest_lat_next = '1;
                min_lat_next    = '0;
                min_valid_next  = 1'b0;
                creep_cnt_next  = '0;
                last_time_next  = ev.now_ms;
                if (ev.new_stream)
                begin
                    retry_next = '0;
                end
            end
            shw_pkg::FUNC_BASELINE:
            begin
                min_lat_next   = '0;
                min_valid_next = 1'b0;
                creep_cnt_next = '0;
            end
            default: ;
        endcase
    end

    // Creep after the event, saturated to the output width
    assign creep_new = min_valid_next
        ? ($signed({latest_lat_next[shw_pkg::LAT_W-1], latest_lat_next})
           - $signed({min_lat_next[shw_pkg::LAT_W-1], min_lat_next}))
        : '0;

    always_comb
    begin
        if (creep_new[shw_pkg::LAT_W] != creep_new[shw_pkg::LAT_W-1])
        begin
            creep_sat = creep_new[shw_pkg::LAT_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            creep_sat = creep_new[shw_pkg::LAT_W-1:0];
        end
    end

    // Assemble the result
    assign res.reconnect   = (cause != shw_pkg::CAUSE_NONE);
    assign res.cause       = cause;
    assign res.backoff_ms  = (cause != shw_pkg::CAUSE_NONE) ? backoff : '0;
    assign res.attempt     = retry_next;
    assign res.creep_ms    = creep_sat;
    assign res.first_frame = first;
    assign res.active      = active_next;

    // Commit the new state when the event moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            frame_seen_reg <= 1'b0;
            last_time_reg  <= '0;
            latest_lat_reg <= '1;
            min_lat_reg    <= '0;
            min_valid_reg  <= 1'b0;
            creep_cnt_reg  <= '0;
            retry_reg      <= '0;
        end
        else if (fire)
        begin
            active_reg     <= active_next;
            frame_seen_reg <= frame_seen_next;
            last_time_reg  <= last_time_next;
            latest_lat_reg <= latest_lat_next;
            min_lat_reg    <= min_lat_next;
            min_valid_reg  <= min_valid_next;
            creep_cnt_reg  <= creep_cnt_next;
            retry_reg      <= retry_next;
        end
    end

endmodule

// ===== sv/stream_health_watchdog_top.sv =====
// Top level of the stream health watchdog: event register, core and result register.
//
// Usage:
//   Events (frame, tick, session start, baseline reset) enter on the ev_* channel
//   and are taken at a rising edge with ev_valid high and ev_stall low. Each
//   event produces exactly one result on the res_* channel, taken at an edge
//   with res_valid high and res_stall low.
//   An event taken into the event register is evaluated from there and its
//   result is written to the result register (two register stages).
//   Throughput: one event per cycle while res_stall is low; the event
//   register and the result register are separate, so a new event is taken
//   while a result waits. When res_stall holds a full result register, the
//   event register fills and then ev_stall rises until the result is taken.
//   Configuration writes go through cfg_valid/cfg_ready (ready is always high);
//   the user must make them only while no event is in flight (not enforced).
//   Reset clears the session (inactive, no retries, no minimum latency), sets
//   the configuration registers to their defaults and empties both stages.
`timescale 1ns / 1ps

module stream_health_watchdog_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // Event channel
    input  logic                          ev_valid,
    output logic                          ev_stall,
    input  logic [1:0]                    func,
    input  logic [shw_pkg::NOW_W-1:0]     now_ms,
    input  logic                          latency_valid,
    input  logic signed [shw_pkg::LAT_W-1:0] latency_ms,
    input  logic                          new_stream,
    // Result channel
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          reconnect,
    output logic [1:0]                    cause,
    output logic [shw_pkg::MS_W-1:0]      backoff_ms,
    output logic [shw_pkg::RETRY_W-1:0]   attempt,
    output logic signed [shw_pkg::LAT_W-1:0] creep_ms,
    output logic                          first_frame,
    output logic                          active,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [shw_pkg::MS_W-1:0]      cfg_data
);

    shw_pkg::cfg_t    cfg;
    shw_pkg::event_t  ev_reg;
    shw_pkg::result_t res;
    shw_pkg::result_t res_reg;
    logic             ev_valid_reg;
    logic             res_valid_reg;
    logic             ev_take;
    logic             advance;

    // Move the held request forward when the result register is free
    assign advance  = ev_valid_reg && (!res_valid_reg || !res_stall);
    assign ev_stall = ev_valid_reg && !advance;
    assign ev_take  = ev_valid && !ev_stall;

    shw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    shw_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .ev    (ev_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Track occupancy of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg  <= ev_take || (ev_valid_reg && !advance);
            res_valid_reg <= advance || (res_valid_reg && res_stall);
        end
    end

    // Capture the incoming request and the finished result
    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            ev_reg.func          <= func;
            ev_reg.now_ms        <= now_ms;
            ev_reg.latency_valid <= latency_valid;
            ev_reg.latency_ms    <= latency_ms;
            ev_reg.new_stream    <= new_stream;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign res_valid   = res_valid_reg;
    assign reconnect   = res_reg.reconnect;
    assign cause       = res_reg.cause;
    assign backoff_ms  = res_reg.backoff_ms;
    assign attempt     = res_reg.attempt;
    assign creep_ms    = res_reg.creep_ms;
    assign first_frame = res_reg.first_frame;
    assign active      = res_reg.active;

endmodule

// ===== sv/shw_checker.sv =====
// Port-level checker for the stream health watchdog and its bind to the top level.
`timescale 1ns / 1ps

module shw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic                          reconnect,
    input logic [1:0]                    cause,
    input logic [shw_pkg::MS_W-1:0]      backoff_ms,
    input logic [shw_pkg::RETRY_W-1:0]   attempt,
    input logic [shw_pkg::LAT_W-1:0]     creep_ms,
    input logic                          first_frame,
    input logic                          active
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(reconnect) && $stable(cause)
            && $stable(backoff_ms) && $stable(attempt) && $stable(creep_ms)
            && $stable(first_frame) && $stable(active))
        else $error("stalled result changed");

    // Reconnect flag agrees with the cause code
    a_cause_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (reconnect == (cause != shw_pkg::CAUSE_NONE)))
        else $error("reconnect flag and cause disagree");

    // A reconnect ends the session and only ticks can request one
    a_reconnect_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && reconnect |-> !active && !first_frame)
        else $error("session still active after reconnect");

    // The first frame of a session clears the retry count
    a_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && first_frame |-> active && (attempt == '0)
            && (cause == shw_pkg::CAUSE_NONE) && (backoff_ms == '0))
        else $error("first frame left retries or a reconnect");

endmodule

bind stream_health_watchdog_top shw_checker u_shw_checker (.*);

// ===== bench/stream_health_watchdog_top_tb.sv =====
// Testbench for stream_health_watchdog_top: predicted event results are checked against the ports.
`timescale 1ns / 1ps

module stream_health_watchdog_top_tb;

    import shw_pkg::*;

    localparam int          NUM_PHASES     = 8;
    localparam int          STORM_PHASE    = 4;
    localparam int          PRESSURE_PHASE = 5;
    localparam int unsigned PHASE_EVENTS   = 190;
    localparam int unsigned STORM_EVENTS   = 520;
    localparam int unsigned PRESSURE_HOLD  = 80;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned DRAIN_LIMIT    = 5000;
    localparam longint      CREEP_HI       = 64'sd2147483647;
    localparam longint      CREEP_LO       = -64'sd2147483648;

    // Scoreboard: predicts each event result and matches it with the ports
    class watchdog_scoreboard;
        cfg_t                   cfg;
        bit                     session_active;
        bit                     frame_seen;
        bit                     min_valid;
        bit [NOW_W-1:0]         last_time;
        bit signed [LAT_W-1:0]  latest_lat;
        bit signed [LAT_W-1:0]  min_lat;
        bit [CNT_W-1:0]         creep_cnt;
        bit [RETRY_W-1:0]       retries;
        result_t                expected_q[$];
        int unsigned            mismatches;
        int unsigned            checked;
        int unsigned            timeouts;
        int unsigned            creeps;
        int unsigned            firsts;
        int unsigned            top_attempt;

        function new();
            cfg = {RST_TIMEOUT, RST_CREEP_LIMIT, RST_CREEP_TICKS,
                   RST_BACKOFF_BASE, RST_BACKOFF_CAP, RST_MAX_SHIFT};
            session_active = 1'b0;
            frame_seen     = 1'b0;
            min_valid      = 1'b0;
            last_time      = '0;
            latest_lat     = -1;
            min_lat        = '0;
            creep_cnt      = '0;
            retries        = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] data);
            case (idx)
                REG_TIMEOUT:      cfg.timeout_ms         = data;
                REG_CREEP_LIMIT:  cfg.creep_limit_ms     = data;
                REG_CREEP_TICKS:  cfg.creep_ticks_needed = data[CNT_W-1:0];
                REG_BACKOFF_BASE: cfg.backoff_base_ms    = data;
                REG_BACKOFF_CAP:  cfg.backoff_cap_ms     = data;
                REG_MAX_SHIFT:    cfg.backoff_max_shift  = data[CNT_W-1:0];
                default:          ;
            endcase
        endfunction

        function longint creep_now();
            return min_valid ? (longint'(latest_lat) - longint'(min_lat)) : 64'sd0;
        endfunction

        // Advance the session state by one event; return 1 if the event was not ignored
        function bit note_event(event_t ev);
            result_t               want;
            logic [1:0]            why;
            bit signed [LAT_W-1:0] lat;
            bit                    was_active;
            longint                silence;
            longint                creep;
            bit [31:0]             delay;
            bit [CNT_W-1:0]        shift;
            want       = '0;
            why        = CAUSE_NONE;
            lat        = $signed(ev.latency_ms);
            was_active = session_active;
            case (ev.func)
                FUNC_FRAME:
                begin
                    if (session_active)
                    begin
                        last_time = ev.now_ms;
                        if (!frame_seen)
                        begin
                            want.first_frame = 1'b1;
                            frame_seen       = 1'b1;
                            retries          = '0;
                            firsts++;
                        end
                        if (ev.latency_valid)
                        begin
                            latest_lat = lat;
                            if (!min_valid || lat < min_lat)
                            begin
                                min_lat   = lat;
                                min_valid = 1'b1;
                            end
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if (session_active)
                    begin
                        // Silence is a signed difference, so time going backwards never times out
                        silence = longint'({16'd0, ev.now_ms}) - longint'({16'd0, last_time});
                        if (silence > longint'({48'd0, cfg.timeout_ms}))
                            why = CAUSE_TIMEOUT;
                        else if (creep_now() <= longint'({48'd0, cfg.creep_limit_ms}))
                            creep_cnt = '0;
                        else
                        begin
                            if (creep_cnt != CREEP_CNT_MAX)
                                creep_cnt++;
                            if (creep_cnt >= cfg.creep_ticks_needed)
                                why = CAUSE_CREEP;
                        end
                        // Backoff uses the retry count before the increment
                        if (why != CAUSE_NONE)
                        begin
                            shift = (retries < {4'd0, cfg.backoff_max_shift}) ?
                                    retries[CNT_W-1:0] : cfg.backoff_max_shift;
                            delay = {16'd0, cfg.backoff_base_ms} << shift;
                            want.backoff_ms = (delay < {16'd0, cfg.backoff_cap_ms}) ?
                                              delay[MS_W-1:0] : cfg.backoff_cap_ms;
                            if (retries != RETRY_MAX)
                                retries++;
                            session_active = 1'b0;
                            frame_seen     = 1'b0;
                            if (why == CAUSE_TIMEOUT)
                                timeouts++;
                            else
                                creeps++;
                        end
                    end
                end
                FUNC_START:
                begin
                    session_active = 1'b1;
                    frame_seen     = 1'b0;
                    latest_lat     = -1;
                    min_lat        = '0;
                    min_valid      = 1'b0;
                    creep_cnt      = '0;
                    last_time      = ev.now_ms;
                    if (ev.new_stream)
                        retries = '0;
                end
                default:
                begin
                    min_lat   = '0;
                    min_valid = 1'b0;
                    creep_cnt = '0;
                end
            endcase

            // Saturate the reported creep to 32 bits
            creep = creep_now();
            if (creep > CREEP_HI)
                creep = CREEP_HI;
            if (creep < CREEP_LO)
                creep = CREEP_LO;

            want.reconnect = (why != CAUSE_NONE);
            want.cause     = why;
            want.attempt   = retries;
            want.creep_ms  = creep[LAT_W-1:0];
            want.active    = session_active;
            if (retries > top_attempt)
                top_attempt = retries;
            expected_q.push_back(want);
            return was_active || ev.func == FUNC_START || ev.func == FUNC_BASELINE;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at result %0d: %s", checked, msg);
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result arrived with no pending request");
                return;
            end
            want = expected_q.pop_front();
            check_field("reconnect", got.reconnect, want.reconnect);
            check_field("cause", got.cause, want.cause);
            check_field("backoff_ms", got.backoff_ms, want.backoff_ms);
            check_field("attempt", got.attempt, want.attempt);
            check_field("creep_ms", got.creep_ms, want.creep_ms);
            check_field("first_frame", got.first_frame, want.first_frame);
            check_field("active", got.active, want.active);
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     ev_valid;
    logic                     ev_stall;
    logic [1:0]               func;
    logic [NOW_W-1:0]         now_ms;
    logic                     latency_valid;
    logic signed [LAT_W-1:0]  latency_ms;
    logic                     new_stream;
    logic                     res_valid;
    logic                     res_stall;
    logic                     reconnect;
    logic [1:0]               cause;
    logic [MS_W-1:0]          backoff_ms;
    logic [RETRY_W-1:0]       attempt;
    logic signed [LAT_W-1:0]  creep_ms;
    logic                     first_frame;
    logic                     active;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [MS_W-1:0]          cfg_data;

    watchdog_scoreboard sb = new();
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct = 0;
    bit                 pressure_request = 1'b0;
    bit [NOW_W-1:0]     tb_now = '0;

    int unsigned idle_send[NUM_PHASES] = '{0, 54, 0, 23, 0, 0, 0, 23};
    int unsigned idle_recv[NUM_PHASES] = '{0, 0, 54, 23, 0, 0, 54, 23};

    stream_health_watchdog_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev_valid      (ev_valid),
        .ev_stall      (ev_stall),
        .func          (func),
        .now_ms        (now_ms),
        .latency_valid (latency_valid),
        .latency_ms    (latency_ms),
        .new_stream    (new_stream),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .reconnect     (reconnect),
        .cause         (cause),
        .backoff_ms    (backoff_ms),
        .attempt       (attempt),
        .creep_ms      (creep_ms),
        .first_frame   (first_frame),
        .active        (active),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Hold off the result side: random stalls plus one long stretch on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_request)
            begin
                pressure_request = 1'b0;
                hold_left        = PRESSURE_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result({reconnect, cause, backoff_ms, attempt, creep_ms,
                             first_frame, active});
    end

    // Offer one request, with random idle gaps, and note it once accepted
    task automatic send_event(event_t ev, output bit counted);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            ev_valid <= 1'b0;
            @(negedge clk);
        end
        ev_valid      <= 1'b1;
        func          <= ev.func;
        now_ms        <= ev.now_ms;
        latency_valid <= ev.latency_valid;
        latency_ms    <= ev.latency_ms;
        new_stream    <= ev.new_stream;
        do
            @(posedge clk);
        while (ev_stall);
        counted = sb.note_event(ev);
    endtask

    task automatic send_fields(logic [1:0] f, logic [NOW_W-1:0] t, logic lv,
                               logic [LAT_W-1:0] lat, logic ns);
        event_t ev;
        bit     counted;
        ev = {f, t, lv, lat, ns};
        send_event(ev, counted);
    endtask

    task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic drain_pipeline();
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        ev_valid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic cfg_t phase_config(int p);
        cfg_t c;
        c.timeout_ms         = MS_W'($urandom_range(50, 3000));
        c.creep_limit_ms     = MS_W'($urandom_range(10, 3000));
        c.creep_ticks_needed = CNT_W'($urandom_range(0, 4));
        c.backoff_base_ms    = MS_W'($urandom_range(1, 65535));
        c.backoff_cap_ms     = MS_W'($urandom_range(1, 65535));
        c.backoff_max_shift  = CNT_W'($urandom_range(0, 15));
        case (p)
            1: c = {16'd1, 16'd1, 4'd0, 16'd1, 16'd1, 4'd0};
            2: c = {16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 4'hF};
            STORM_PHASE:
            begin
                c.timeout_ms         = 16'd1;
                c.creep_limit_ms     = 16'hFFFF;
                c.creep_ticks_needed = 4'hF;
                c.backoff_base_ms    = MS_W'($urandom_range(1, 7));
                c.backoff_cap_ms     = 16'hFFFF;
                c.backoff_max_shift  = 4'hF;
            end
            PRESSURE_PHASE:
                c = {RST_TIMEOUT, RST_CREEP_LIMIT, RST_CREEP_TICKS,
                     RST_BACKOFF_BASE, RST_BACKOFF_CAP, RST_MAX_SHIFT};
            default: ;
        endcase
        return c;
    endfunction

    task automatic apply_config(cfg_t c);
        program_register(REG_TIMEOUT, c.timeout_ms);
        program_register(REG_CREEP_LIMIT, c.creep_limit_ms);
        program_register(REG_CREEP_TICKS, {12'd0, c.creep_ticks_needed});
        program_register(REG_BACKOFF_BASE, c.backoff_base_ms);
        program_register(REG_BACKOFF_CAP, c.backoff_cap_ms);
        program_register(REG_MAX_SHIFT, {12'd0, c.backoff_max_shift});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Build the next random event: mostly live sessions, some noise
    task automatic next_event(bit storm, output event_t ev);
        int unsigned pick;
        int unsigned mode;
        ev.func          = FUNC_TICK;
        ev.latency_valid = 1'($urandom_range(0, 1));
        ev.latency_ms    = $urandom;
        ev.new_stream    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (storm)
        begin
            // Back-to-back timeouts without frames drive the retry count to saturation
            if (!sb.session_active)
            begin
                ev.func       = (pick < 5) ? FUNC_BASELINE : FUNC_START;
                ev.new_stream = 1'b0;
            end
            else
                tb_now = sb.last_time + $urandom_range(2, 50);
        end
        else if (!sb.session_active && pick < 75)
        begin
            ev.func = FUNC_START;
            if ($urandom_range(0, 19) == 0)
                tb_now = NOW_W'({$urandom, $urandom});
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                ev.func = FUNC_START;
            else if (pick < 7)
                ev.func = FUNC_BASELINE;
            else if (pick < 55)
            begin
                ev.func          = FUNC_FRAME;
                tb_now           = tb_now + $urandom_range(0, 50);
                ev.latency_valid = ($urandom_range(0, 4) != 0);
                mode = $urandom_range(0, 9);
                if (mode == 0)
                    ev.latency_ms = $urandom;
                else if (mode < 3)
                    ev.latency_ms = $urandom_range(0, 200) - 100;
                else
                    ev.latency_ms = 1000 + $urandom_range(0, 2 * sb.cfg.creep_limit_ms + 2);
            end
            else
            begin
                mode = $urandom_range(0, 19);
                if (mode == 0)
                    tb_now = tb_now - $urandom_range(1, 100000);
                else if (mode < 4)
                    tb_now = sb.last_time + sb.cfg.timeout_ms + $urandom_range(0, 3) - 1;
                else
                    tb_now = tb_now + $urandom_range(0, sb.cfg.timeout_ms / 8);
            end
        end
        ev.now_ms = tb_now;
    endtask

    // Directed events on reset settings: ignored events, both causes, edges
    task automatic run_directed();
        send_fields(FUNC_TICK, 48'd500, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_FRAME, 48'd600, 1'b1, 32'd123, 1'b1);
        send_fields(FUNC_BASELINE, 48'd700, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_START, 48'd1000, 1'b0, 32'd0, 1'b1);
        send_fields(FUNC_FRAME, 48'd1100, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_FRAME, 48'd1150, 1'b1, 32'd100, 1'b0);
        send_fields(FUNC_FRAME, 48'd1200, 1'b1, 32'd50, 1'b0);
        send_fields(FUNC_FRAME, 48'd1250, 1'b1, 32'd6000, 1'b0);
        send_fields(FUNC_TICK, 48'd1300, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_TICK, 48'd1400, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_TICK, 48'd1500, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_TICK, 48'd1600, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_START, 48'd2000, 1'b0, 32'd0, 1'b0);
        // Silence exactly at the timeout, then one past it
        send_fields(FUNC_TICK, 48'd14000, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_TICK, 48'd14001, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_START, 48'hFFFF_FFFF_FFFF, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_FRAME, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0);
        // Creep wider than 32 bits saturates
        send_fields(FUNC_FRAME, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0);
        // Time going backwards never times out
        send_fields(FUNC_TICK, 48'd0, 1'b0, 32'd0, 1'b0);
        send_fields(FUNC_BASELINE, 48'd0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_fields(FUNC_FRAME, 48'd10, 1'b1, 32'hFFFF_FFFB, 1'b0);
        // Start while already active restarts the session
        send_fields(FUNC_START, 48'd20, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_fields(FUNC_FRAME, 48'd30, 1'b1, 32'd0, 1'b1);
        send_fields(FUNC_TICK, 48'd40, 1'b1, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Abort a hung run
    initial
    begin
        #400000;
        $display("stream_health_watchdog_top regression: fail");
        $finish;
    end

    initial
    begin
        event_t      ev;
        bit          counted;
        int unsigned taken;
        int unsigned quota;
        ev_valid      = 1'b0;
        func          = FUNC_FRAME;
        now_ms        = '0;
        latency_valid = 1'b0;
        latency_ms    = '0;
        new_stream    = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_TIMEOUT;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        tb_now = 48'd100000;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_pipeline();
            if (p != 0)
                apply_config(phase_config(p));
            send_idle_pct = idle_send[p];
            stall_pct     = idle_recv[p];
            if (p == PRESSURE_PHASE)
                pressure_request = 1'b1;
            quota = (p == STORM_PHASE) ? STORM_EVENTS : PHASE_EVENTS;
            taken = 0;
            while (taken < quota)
            begin
                next_event(p == STORM_PHASE, ev);
                send_event(ev, counted);
                taken += counted;
            end
        end

        drain_pipeline();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Checked %0d results over %0d setting phases plus a directed block",
                 sb.checked, NUM_PHASES);
        $display("Reconnects: %0d on silence, %0d on creep; %0d first frames; top attempt %0d",
                 sb.timeouts, sb.creeps, sb.firsts, sb.top_attempt);
        if (sb.mismatches == 0)
            $display("stream_health_watchdog_top regression: pass");
        else
            $display("stream_health_watchdog_top regression: fail");
        $finish;
    end

endmodule
